[design/zpk_pkg.sv]
// types and constants used by the zoom cue evaluator
package zpk_pkg;

  // request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_EASE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCALE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCALE = 4'd3;

  // fixed point constants
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [15:0] UNIT_SCALE = 16'd256;

  // serial divider sizes
  localparam int unsigned DIVN_W = 48;
  localparam int unsigned DIVD_W = 27;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] cue_start_ms;
    logic [31:0] cue_end_ms;
    logic [15:0] ease_in_ms;
    logic [15:0] ease_out_ms;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [15:0] zoom_scale;
    logic [31:0] query_time_ms;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        in_cue;
    logic [15:0] view_scale;
    logic [15:0] view_centre_x;
    logic [15:0] view_centre_y;
  } rsp_t;

  // one stored cue
  typedef struct packed {
    logic [15:0] scale;
    logic [15:0] target_y;
    logic [15:0] target_x;
    logic [15:0] ease_out;
    logic [15:0] ease_in;
    logic [31:0] end_ms;
    logic [31:0] start_ms;
  } cue_t;

endpackage

[design/zpk_ram.sv]
// generic single write port ram with registered read
module zpk_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/zoom_pan_keyframe_evaluator.sv]
// zoom cue table with sorted load and keyframe view evaluation at a query time
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_req_i (req_t)
//   out      output     out_valid_o/out_stall_i out_rsp_o (rsp_t)
//   cfg      input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// one request at a time; clear and unused codes go straight to the output hand-off.
// a load shifts each cue with a later start up one place (one ram read and one write
// each), then writes the new cue; a refused cue or an empty table skips the shift.
// a query walks the cue ram one entry read at a time, then runs up to six 48-bit
// serial divisions and the smoothstep and blend multiply steps.
// reset clears the cue count and control state; cue ram contents are never cleared.
// a new request is taken while a finished result waits under out_stall_i.
module zoom_pan_keyframe_evaluator
  import zpk_pkg::*;
#(
  parameter int unsigned MAX_CUES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_wdata_i
);

  localparam int unsigned AW    = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CUES + 1);
  localparam logic [5:0] DIV_LAST = 6'(DIVN_W - 1);

  // state codes
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_LD_CHK  = 5'd1;
  localparam logic [4:0] ST_LD_RD   = 5'd2;
  localparam logic [4:0] ST_LD_CMP  = 5'd3;
  localparam logic [4:0] ST_LD_PUT  = 5'd4;
  localparam logic [4:0] ST_Q_RD    = 5'd5;
  localparam logic [4:0] ST_Q_STEP  = 5'd6;
  localparam logic [4:0] ST_Q_LAST  = 5'd7;
  localparam logic [4:0] ST_E_LEN   = 5'd8;
  localparam logic [4:0] ST_E_CHK   = 5'd9;
  localparam logic [4:0] ST_E_SPL   = 5'd10;
  localparam logic [4:0] ST_E_FIX   = 5'd11;
  localparam logic [4:0] ST_E_CLAMP = 5'd12;
  localparam logic [4:0] ST_S_DIV   = 5'd13;
  localparam logic [4:0] ST_S_X     = 5'd14;
  localparam logic [4:0] ST_S_P1    = 5'd15;
  localparam logic [4:0] ST_S_P2    = 5'd16;
  localparam logic [4:0] ST_S_P3    = 5'd17;
  localparam logic [4:0] ST_S_P4    = 5'd18;
  localparam logic [4:0] ST_I_DIV   = 5'd19;
  localparam logic [4:0] ST_I_SET   = 5'd20;
  localparam logic [4:0] ST_M_RUN   = 5'd21;
  localparam logic [4:0] ST_F_DIV   = 5'd22;
  localparam logic [4:0] ST_F_SET   = 5'd23;
  localparam logic [4:0] ST_DIV     = 5'd24;
  localparam logic [4:0] ST_OUT     = 5'd25;

  logic [4:0]       state_q, ret_q;
  logic [CNT_W-1:0] count_q, k_q, idx_q;
  logic [15:0]      min_cue_q, min_ease_q, min_scale_q, max_scale_q;
  req_t             req_q;
  rsp_t             res_q, out_rsp_q;
  logic             out_valid_q;

  // walk registers
  cue_t        h_q, cur_q, ps_q;
  logic        h_valid_q, found_q, ps_valid_q, has_next_q;
  logic [31:0] cur_te_q, ps_te_q;

  // evaluation registers
  logic [31:0] len_q;
  logic [16:0] ein_q, eout_q, x_q, wi_q, wl_q;
  logic [20:0] inner_q;
  logic        sel_q, isel_q;
  logic [24:0] ti_q, fi_q;
  logic [16:0] tx_q, ty_q, fx_q, fy_q;
  logic [2:0]  mstep_q;
  logic signed [27:0] acc_inv_q, acc_x_q, acc_y_q;

  // serial divider registers
  logic [DIVN_W-1:0] div_n_q;
  logic [DIVD_W-1:0] div_d_q, div_r_q;
  logic [5:0]        div_cnt_q;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [57:0] mul_p_q;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  cue_t          ram_wdata, rd_cue;

  zpk_ram #(
    .WIDTH ($bits(cue_t)),
    .DEPTH (MAX_CUES),
    .ADDR_W(AW)
  ) u_cue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rd_cue)
  );

  // handshake
  logic in_acc, out_load;
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // new cue from the latched load request, scale clamped
  cue_t        new_cue;
  logic [15:0] sc_clamp;
  logic        ld_refuse;
  always_comb begin
    sc_clamp = req_q.zoom_scale;
    if (sc_clamp > max_scale_q) begin
      sc_clamp = max_scale_q;
    end
    if (sc_clamp < min_scale_q) begin
      sc_clamp = min_scale_q;
    end
    new_cue.start_ms = req_q.cue_start_ms;
    new_cue.end_ms   = req_q.cue_end_ms;
    new_cue.ease_in  = req_q.ease_in_ms;
    new_cue.ease_out = req_q.ease_out_ms;
    new_cue.target_x = req_q.target_x;
    new_cue.target_y = req_q.target_y;
    new_cue.scale    = sc_clamp;
    ld_refuse = (count_q >= CNT_W'(MAX_CUES))
             || (req_q.cue_end_ms < req_q.cue_start_ms)
             || ((req_q.cue_end_ms - req_q.cue_start_ms) < {16'd0, min_cue_q})
             || (req_q.zoom_scale <= min_scale_q);
  end

  // trimming and survival of the held cue during the walk
  logic [31:0] h_te;
  logic        h_surv, h_hit;
  logic [31:0] qt;
  assign qt = req_q.query_time_ms;
  always_comb begin
    h_te = h_q.end_ms;
    if ((state_q == ST_Q_STEP) && (rd_cue.start_ms < h_q.end_ms)) begin
      h_te = rd_cue.start_ms;
    end
    h_surv = (h_te >= h_q.start_ms) && ((h_te - h_q.start_ms) >= {16'd0, min_cue_q});
    h_hit  = h_surv && (qt >= h_q.start_ms) && (qt < h_te);
  end

  // ram access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q[AW-1:0];
    ram_wdata = new_cue;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    case (state_q)
      ST_LD_CHK: begin
        ram_we    = !ld_refuse && (count_q == '0);
        ram_waddr = '0;
      end
      ST_LD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(k_q - CNT_W'(1));
      end
      ST_LD_CMP: begin
        ram_we = 1'b1;
        if (rd_cue.start_ms > req_q.cue_start_ms) begin
          ram_wdata = rd_cue;
        end
      end
      ST_LD_PUT: begin
        ram_we = 1'b1;
      end
      ST_Q_RD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // divider step
  logic [DIVD_W:0]   div_rsh;
  logic              div_ge;
  assign div_rsh = {div_r_q, div_n_q[DIVN_W-1]};
  assign div_ge  = div_rsh >= {1'b0, div_d_q};

  // scale inverse and clamped centre helpers
  logic [15:0] isc;
  logic [16:0] half_c, hi_c, bx, by;
  logic [15:0] vx, vy;
  always_comb begin
    isc    = isel_q ? ps_q.scale : cur_q.scale;
    vx     = isel_q ? ps_q.target_x : cur_q.target_x;
    vy     = isel_q ? ps_q.target_y : cur_q.target_y;
    half_c = div_n_q[17:1];
    hi_c   = ONE_Q16 - half_c;
    if (isc <= UNIT_SCALE) begin
      bx = HALF_Q16;
      by = HALF_Q16;
    end else begin
      bx = {1'b0, vx};
      by = {1'b0, vy};
      if (bx > hi_c) bx = hi_c;
      if (bx < half_c) bx = half_c;
      if (by > hi_c) by = hi_c;
      if (by < half_c) by = half_c;
    end
  end

  // smoothstep inner polynomial term
  logic [17:0] pp;
  logic [22:0] inner_w;
  assign pp      = mul_p_q[33:16];
  assign inner_w = ({5'd0, pp} << 2) + ({5'd0, pp} << 1) + 23'd655360
                 - ({6'd0, x_q} << 4) + {6'd0, x_q};

  // blend operands
  logic signed [35:0] ti_s, fi_s, ai_s, tx_s, ty_s, fx_s, fy_s, ax_s, ay_s;
  assign ti_s = $signed({11'd0, ti_q});
  assign fi_s = $signed({11'd0, fi_q});
  assign ai_s = has_next_q ? ti_s : $signed({19'd0, ONE_Q16});
  assign tx_s = $signed({19'd0, tx_q});
  assign ty_s = $signed({19'd0, ty_q});
  assign fx_s = $signed({19'd0, fx_q});
  assign fy_s = $signed({19'd0, fy_q});
  assign ax_s = has_next_q ? tx_s : $signed({19'd0, HALF_Q16});
  assign ay_s = has_next_q ? ty_s : $signed({19'd0, HALF_Q16});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_E_CHK: begin
        mul_a = $signed({19'd0, ein_q});
        mul_b = $signed({5'd0, len_q[16:0]});
      end
      ST_S_P1: begin
        mul_a = $signed({19'd0, x_q});
        mul_b = $signed({5'd0, x_q});
      end
      ST_S_P2: begin
        mul_a = $signed({2'd0, mul_p_q[33:0]});
        mul_b = $signed({5'd0, x_q});
      end
      ST_S_P3: begin
        mul_a = $signed({19'd0, mul_p_q[48:32]});
        mul_b = $signed({1'b0, inner_q});
      end
      ST_M_RUN: begin
        case (mstep_q)
          3'd0: begin mul_a = fi_s - ti_s; mul_b = $signed({5'd0, wi_q}); end
          3'd1: begin mul_a = ai_s - ti_s; mul_b = $signed({5'd0, wl_q}); end
          3'd2: begin mul_a = fx_s - tx_s; mul_b = $signed({5'd0, wi_q}); end
          3'd3: begin mul_a = ax_s - tx_s; mul_b = $signed({5'd0, wl_q}); end
          3'd4: begin mul_a = fy_s - ty_s; mul_b = $signed({5'd0, wi_q}); end
          3'd5: begin mul_a = ay_s - ty_s; mul_b = $signed({5'd0, wl_q}); end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
  end

  // product divided by 2^16, truncated toward zero
  logic signed [57:0] mul_rnd;
  logic signed [27:0] mul_q16;
  assign mul_rnd = mul_p_q[57] ? (mul_p_q + 58'sd65535) : mul_p_q;
  assign mul_q16 = 28'(mul_rnd >>> 16);

  // quotient saturation and centre clipping for the result
  logic [15:0] sat_scale, clip_x, clip_y;
  always_comb begin
    sat_scale = (div_n_q > DIVN_W'(65535)) ? 16'hFFFF : div_n_q[15:0];
    if (acc_x_q < 0) clip_x = 16'd0;
    else if (acc_x_q > 28'sd65535) clip_x = 16'hFFFF;
    else clip_x = acc_x_q[15:0];
    if (acc_y_q < 0) clip_y = 16'd0;
    else if (acc_y_q > 28'sd65535) clip_y = 16'hFFFF;
    else clip_y = acc_y_q[15:0];
  end

  logic [31:0] s_num;
  logic [16:0] s_den, sum_e;
  assign s_num = sel_q ? (cur_te_q - qt) : (qt - cur_q.start_ms);
  assign s_den = sel_q ? eout_q : ein_q;
  assign sum_e = ein_q + eout_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= res_q;
    end
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      min_cue_q   <= 16'd100;
      min_ease_q  <= 16'd50;
      min_scale_q <= 16'd256;
      max_scale_q <= 16'd2048;
      h_valid_q   <= 1'b0;
      found_q     <= 1'b0;
      ps_valid_q  <= 1'b0;
      has_next_q  <= 1'b0;
      sel_q       <= 1'b0;
      isel_q      <= 1'b0;
      mstep_q     <= '0;
      div_cnt_q   <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MIN_CUE:   min_cue_q   <= cfg_wdata_i;
          CFG_MIN_EASE:  min_ease_q  <= cfg_wdata_i;
          CFG_MIN_SCALE: min_scale_q <= cfg_wdata_i;
          CFG_MAX_SCALE: max_scale_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            req_q <= in_req_i;
            unique case (in_req_i.req_type)
              REQ_CLEAR: begin
                count_q <= '0;
                res_q   <= '{accepted: 1'b1, in_cue: 1'b0, view_scale: 16'd0,
                             view_centre_x: 16'd0, view_centre_y: 16'd0};
                state_q <= ST_OUT;
              end
              REQ_LOAD: begin
                res_q   <= '0;
                state_q <= ST_LD_CHK;
              end
              REQ_QUERY: begin
                res_q      <= '{accepted: 1'b1, in_cue: 1'b0, view_scale: UNIT_SCALE,
                                view_centre_x: HALF_Q16[15:0],
                                view_centre_y: HALF_Q16[15:0]};
                idx_q      <= '0;
                h_valid_q  <= 1'b0;
                found_q    <= 1'b0;
                ps_valid_q <= 1'b0;
                has_next_q <= 1'b0;
                state_q    <= (count_q == '0) ? ST_OUT : ST_Q_RD;
              end
              REQ_NONE: begin
                res_q   <= '0;
                state_q <= ST_OUT;
              end
              default: begin
                res_q   <= '0;
                state_q <= ST_OUT;
              end
            endcase
          end
        end

        // load: filter, then shift larger starts up one place
        ST_LD_CHK: begin
          if (ld_refuse) begin
            state_q <= ST_OUT;
          end else if (count_q == '0) begin
            count_q        <= CNT_W'(1);
            res_q.accepted <= 1'b1;
            state_q        <= ST_OUT;
          end else begin
            k_q     <= count_q;
            state_q <= ST_LD_RD;
          end
        end
        ST_LD_RD: begin
          state_q <= ST_LD_CMP;
        end
        ST_LD_CMP: begin
          if (rd_cue.start_ms > req_q.cue_start_ms) begin
            k_q     <= k_q - CNT_W'(1);
            state_q <= (k_q == CNT_W'(1)) ? ST_LD_PUT : ST_LD_RD;
          end else begin
            count_q        <= count_q + CNT_W'(1);
            res_q.accepted <= 1'b1;
            state_q        <= ST_OUT;
          end
        end
        ST_LD_PUT: begin
          count_q        <= count_q + CNT_W'(1);
          res_q.accepted <= 1'b1;
          state_q        <= ST_OUT;
        end

        // query walk, one entry look-ahead for trimming
        ST_Q_RD: begin
          state_q <= ST_Q_STEP;
        end
        ST_Q_STEP: begin
          h_q       <= rd_cue;
          h_valid_q <= 1'b1;
          idx_q     <= idx_q + CNT_W'(1);
          if (h_valid_q && found_q && h_surv) begin
            has_next_q <= (h_q.start_ms == cur_te_q);
            state_q    <= ST_E_LEN;
          end else begin
            if (h_valid_q && !found_q) begin
              if (h_hit) begin
                found_q  <= 1'b1;
                cur_q    <= h_q;
                cur_te_q <= h_te;
              end else if (h_surv) begin
                ps_valid_q <= 1'b1;
                ps_q       <= h_q;
                ps_te_q    <= h_te;
              end
            end
            state_q <= ((idx_q + CNT_W'(1)) == count_q) ? ST_Q_LAST : ST_Q_RD;
          end
        end
        ST_Q_LAST: begin
          if (found_q) begin
            if (h_surv) begin
              has_next_q <= (h_q.start_ms == cur_te_q);
            end
            state_q <= ST_E_LEN;
          end else if (h_hit) begin
            found_q  <= 1'b1;
            cur_q    <= h_q;
            cur_te_q <= h_te;
            state_q  <= ST_E_LEN;
          end else begin
            state_q <= ST_OUT;
          end
        end

        // ramp lengths
        ST_E_LEN: begin
          len_q  <= (cur_te_q > cur_q.start_ms) ? (cur_te_q - cur_q.start_ms) : 32'd1;
          ein_q  <= {1'b0, (cur_q.ease_in < min_ease_q) ? min_ease_q : cur_q.ease_in};
          eout_q <= {1'b0, (cur_q.ease_out < min_ease_q) ? min_ease_q : cur_q.ease_out};
          state_q <= ST_E_CHK;
        end
        ST_E_CHK: begin
          state_q <= ({15'd0, sum_e} > len_q) ? ST_E_SPL : ST_E_CLAMP;
        end
        ST_E_SPL: begin
          div_n_q   <= DIVN_W'(mul_p_q[47:0]);
          div_d_q   <= DIVD_W'(sum_e);
          div_r_q   <= '0;
          div_cnt_q <= '0;
          ret_q     <= ST_E_FIX;
          state_q   <= ST_DIV;
        end
        ST_E_FIX: begin
          ein_q   <= div_n_q[16:0];
          eout_q  <= len_q[16:0] - div_n_q[16:0];
          state_q <= ST_E_CLAMP;
        end
        ST_E_CLAMP: begin
          if (ein_q == '0) ein_q <= 17'd1;
          if (eout_q == '0) eout_q <= 17'd1;
          sel_q   <= 1'b0;
          state_q <= ST_S_DIV;
        end

        // smoothstep of elapsed and remaining time
        ST_S_DIV: begin
          div_n_q   <= {s_num, 16'd0};
          div_d_q   <= DIVD_W'(s_den);
          div_r_q   <= '0;
          div_cnt_q <= '0;
          ret_q     <= ST_S_X;
          state_q   <= ST_DIV;
        end
        ST_S_X: begin
          x_q     <= (div_n_q > DIVN_W'(ONE_Q16)) ? ONE_Q16 : div_n_q[16:0];
          state_q <= ST_S_P1;
        end
        ST_S_P1: begin
          state_q <= ST_S_P2;
        end
        ST_S_P2: begin
          inner_q <= inner_w[20:0];
          state_q <= ST_S_P3;
        end
        ST_S_P3: begin
          state_q <= ST_S_P4;
        end
        ST_S_P4: begin
          if (sel_q) begin
            wl_q    <= ONE_Q16 - mul_p_q[32:16];
            isel_q  <= 1'b0;
            state_q <= ST_I_DIV;
          end else begin
            wi_q    <= ONE_Q16 - mul_p_q[32:16];
            sel_q   <= 1'b1;
            state_q <= ST_S_DIV;
          end
        end

        // inverse scales and clamped centres
        ST_I_DIV: begin
          div_n_q   <= DIVN_W'(1) << 24;
          div_d_q   <= DIVD_W'((isc == 16'd0) ? 16'd1 : isc);
          div_r_q   <= '0;
          div_cnt_q <= '0;
          ret_q     <= ST_I_SET;
          state_q   <= ST_DIV;
        end
        ST_I_SET: begin
          mstep_q <= '0;
          if (isel_q) begin
            fi_q    <= div_n_q[24:0];
            fx_q    <= bx;
            fy_q    <= by;
            state_q <= ST_M_RUN;
          end else begin
            ti_q      <= div_n_q[24:0];
            tx_q      <= bx;
            ty_q      <= by;
            acc_inv_q <= $signed({3'd0, div_n_q[24:0]});
            acc_x_q   <= $signed({11'd0, bx});
            acc_y_q   <= $signed({11'd0, by});
            if (ps_valid_q && (ps_te_q == cur_q.start_ms)) begin
              isel_q  <= 1'b1;
              state_q <= ST_I_DIV;
            end else begin
              fi_q    <= {8'd0, ONE_Q16};
              fx_q    <= HALF_Q16;
              fy_q    <= HALF_Q16;
              state_q <= ST_M_RUN;
            end
          end
        end

        // blend: six products, each accumulated from the registered product
        ST_M_RUN: begin
          mstep_q <= mstep_q + 3'd1;
          case (mstep_q)
            3'd1, 3'd2: acc_inv_q <= acc_inv_q + mul_q16;
            3'd3, 3'd4: acc_x_q   <= acc_x_q + mul_q16;
            3'd5, 3'd6: acc_y_q   <= acc_y_q + mul_q16;
            default: begin
            end
          endcase
          if (mstep_q == 3'd6) begin
            state_q <= ST_F_DIV;
          end
        end

        // final scale from blended inverse
        ST_F_DIV: begin
          res_q.in_cue        <= 1'b1;
          res_q.view_centre_x <= clip_x;
          res_q.view_centre_y <= clip_y;
          if (acc_inv_q <= 0) begin
            res_q.view_scale <= 16'hFFFF;
            state_q          <= ST_OUT;
          end else begin
            div_n_q   <= DIVN_W'(1) << 24;
            div_d_q   <= DIVD_W'(acc_inv_q[26:0]);
            div_r_q   <= '0;
            div_cnt_q <= '0;
            ret_q     <= ST_F_SET;
            state_q   <= ST_DIV;
          end
        end
        ST_F_SET: begin
          res_q.view_scale <= sat_scale;
          state_q          <= ST_OUT;
        end

        // restoring divider, one quotient bit per cycle
        ST_DIV: begin
          if (div_ge) begin
            div_r_q <= DIVD_W'(div_rsh - {1'b0, div_d_q});
          end else begin
            div_r_q <= div_rsh[DIVD_W-1:0];
          end
          div_n_q   <= {div_n_q[DIVN_W-2:0], div_ge};
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == DIV_LAST) begin
            state_q <= ret_q;
          end
        end

        // hand the result to the output register
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // cue count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CUES))
    else $error("cue count beyond table size");

  // the walk never reads past the loaded cues
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RD) |-> (idx_q < count_q))
    else $error("query walk past cue count");

  // a final insert grows the table by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD_PUT) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow cue count");

endmodule
